@@ rtl/mrrc_pkg.sv @@
// mrrc_pkg: shared types, constants and the crc-16 byte update for the
// modbus rtu read reply checker; no dependencies
package mrrc_pkg;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NO_REPLY  = 3'd1,
      ST_EXCEPTION = 3'd2,
      ST_SHORT     = 3'd3,
      ST_BAD_ID    = 3'd4,
      ST_BAD_FUNC  = 3'd5,
      ST_BAD_COUNT = 3'd6,
      ST_CRC       = 3'd7
   } status_type;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_GAP  = 1'b1;

   localparam logic REG_SLAVE_ID  = 1'b0;
   localparam logic REG_REG_COUNT = 1'b1;

   localparam logic [15:0] CRC_INIT       = 16'hFFFF;
   localparam logic [15:0] CRC_POLY       = 16'hA001;
   localparam logic [7:0]  FUNC_READ_HOLD = 8'h03;
   localparam logic [7:0]  FUNC_EXC_BIT   = 8'h80;

   localparam logic [7:0] SLAVE_ID_RESET  = 8'd1;
   localparam logic [3:0] REG_COUNT_RESET = 4'd7;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

@@ rtl/mrrc_word_store.sv @@
// mrrc_word_store: register word memory with separate high and low byte lanes
// and a registered read port; no package dependencies
module mrrc_word_store #(
   parameter int DEPTH  = 8,
   parameter int ADDR_W = 3
) (
   input  logic              clock,
   input  logic              wr_hi,
   input  logic              wr_lo,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [15:0]       rd_data
);

   logic [7:0]  mem_hi [DEPTH];
   logic [7:0]  mem_lo [DEPTH];
   logic [15:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_hi) begin
         mem_hi[wr_addr] <= wr_data;
      end
      if (wr_lo) begin
         mem_lo[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= {mem_hi[rd_addr], mem_lo[rd_addr]};
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/modbus_rtu_read_reply_checker.sv @@
// modbus_rtu_read_reply_checker: function 0x03 reply checker top level
// depends on mrrc_pkg and mrrc_word_store
// an error or gap status passes the pending slot, then the output register; drained words
// also take a registered store read and leave one word per cycle unless the output stalls
// throughput: one byte per cycle; word bytes, gaps and closing bytes wait while words drain
// reset: synchronous, clears frame and output control; the word store is not cleared
module modbus_rtu_read_reply_checker #(
   parameter int MAX_REGS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_op,
   input  logic [7:0]          req_data_byte,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output mrrc_pkg::status_type rsp_status,
   output logic [2:0]          rsp_reg_index,
   output logic [15:0]         rsp_reg_value,
   output logic                rsp_last,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);
   import mrrc_pkg::*;

   localparam int WORDS = (MAX_REGS < 8) ? MAX_REGS : 8;
   localparam int IDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam logic [3:0] LIM = 4'(WORDS);

   // configuration
   logic [7:0] slave_id_ff, slave_id_in;
   logic [3:0] reg_count_ff, reg_count_in;
   logic       csr_wr;

   // frame state
   logic [4:0]  bytes_ff, bytes_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  addr_ff, addr_in;
   logic [7:0]  func_ff, func_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  crc_lo_ff, crc_lo_in;
   logic        done_ff, done_in;

   // drain sequencer
   logic       drain_ff, drain_in;
   logic [2:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] drain_last_ff, drain_last_in;

   // pending result slot
   logic       slot_valid_ff, slot_valid_in;
   logic       slot_word_ff, slot_word_in;
   status_type slot_status_ff, slot_status_in;
   logic [2:0] slot_idx_ff, slot_idx_in;
   logic       slot_last_ff, slot_last_in;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff;
   logic [2:0] rsp_idx_ff;
   logic [15:0] rsp_value_ff;
   logic       rsp_last_ff;

   logic [3:0]  n_eff;
   logic [4:0]  crc_pos;
   logic        is_gap, is_body, is_crclo, is_end;
   logic        word_wr, needs_slot, acc;
   logic        slot_adv, slot_free, drain_issue;
   logic [4:0]  body_off;
   logic [15:0] got_crc;
   status_type  end_status, gap_status;
   logic [15:0] mem_rd_data;

   // configuration port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;
   assign prdata = (paddr[2] == REG_REG_COUNT) ? {28'd0, reg_count_ff} : {24'd0, slave_id_ff};

   always_comb begin
      slave_id_in  = slave_id_ff;
      reg_count_in = reg_count_ff;
      if (csr_wr) begin
         if (paddr[2] == REG_SLAVE_ID) begin
            slave_id_in = pwdata[7:0];
         end else begin
            reg_count_in = pwdata[3:0];
         end
      end
   end

   // effective register count and frame position
   always_comb begin
      if (reg_count_ff == 4'd0) begin
         n_eff = 4'd1;
      end else if (reg_count_ff > LIM) begin
         n_eff = LIM;
      end else begin
         n_eff = reg_count_ff;
      end
   end

   assign crc_pos  = 5'd3 + {n_eff, 1'b0};
   assign is_gap   = (req_op == OP_GAP);
   assign is_body  = (bytes_ff < crc_pos);
   assign is_crclo = (bytes_ff == crc_pos);
   assign is_end   = !is_body && !is_crclo;
   assign body_off = bytes_ff - 5'd3;
   assign got_crc  = {req_data_byte, crc_lo_ff};

   assign word_wr    = !is_gap && !done_ff && is_body && (bytes_ff >= 5'd3);
   assign needs_slot = !done_ff && (is_gap || is_end);

   assign slot_adv  = slot_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign slot_free = !slot_valid_ff || slot_adv;

   assign req_ready = needs_slot ? (!drain_ff && slot_free) : !(word_wr && drain_ff);
   assign acc       = req_valid && req_ready;

   assign drain_issue = drain_ff && slot_free;

   always_comb begin
      if (addr_ff != slave_id_ff) begin
         end_status = ST_BAD_ID;
      end else if (func_ff != FUNC_READ_HOLD) begin
         end_status = ST_BAD_FUNC;
      end else if (count_ff != {3'd0, n_eff, 1'b0}) begin
         end_status = ST_BAD_COUNT;
      end else if (got_crc != crc_ff) begin
         end_status = ST_CRC;
      end else begin
         end_status = ST_OK;
      end
   end

   always_comb begin
      if (bytes_ff == 5'd0) begin
         gap_status = ST_NO_REPLY;
      end else if (bytes_ff == 5'd5 && (func_ff & FUNC_EXC_BIT) != 8'd0) begin
         gap_status = ST_EXCEPTION;
      end else begin
         gap_status = ST_SHORT;
      end
   end

   // frame state update
   always_comb begin
      bytes_in  = bytes_ff;
      crc_in    = crc_ff;
      addr_in   = addr_ff;
      func_in   = func_ff;
      count_in  = count_ff;
      crc_lo_in = crc_lo_ff;
      done_in   = done_ff;
      if (acc) begin
         if (is_gap) begin
            bytes_in  = 5'd0;
            crc_in    = CRC_INIT;
            addr_in   = 8'd0;
            func_in   = 8'd0;
            count_in  = 8'd0;
            crc_lo_in = 8'd0;
            done_in   = 1'b0;
         end else if (!done_ff) begin
            if (is_body) begin
               crc_in   = crc16_byte(crc_ff, req_data_byte);
               bytes_in = bytes_ff + 5'd1;
               case (bytes_ff)
                  5'd0:    addr_in  = req_data_byte;
                  5'd1:    func_in  = req_data_byte;
                  5'd2:    count_in = req_data_byte;
                  default: ;
               endcase
            end else if (is_crclo) begin
               crc_lo_in = req_data_byte;
               bytes_in  = bytes_ff + 5'd1;
            end else begin
               done_in = 1'b1;
            end
         end
      end
   end

   // slot and drain control
   always_comb begin
      drain_in       = drain_ff;
      rd_ptr_in      = rd_ptr_ff;
      drain_last_in  = drain_last_ff;
      slot_valid_in  = slot_valid_ff && !slot_adv;
      slot_word_in   = slot_word_ff;
      slot_status_in = slot_status_ff;
      slot_idx_in    = slot_idx_ff;
      slot_last_in   = slot_last_ff;
      if (acc && needs_slot) begin
         if (!is_gap && end_status == ST_OK) begin
            drain_in      = 1'b1;
            rd_ptr_in     = 3'd0;
            drain_last_in = 3'(n_eff - 4'd1);
         end else begin
            slot_valid_in  = 1'b1;
            slot_word_in   = 1'b0;
            slot_status_in = is_gap ? gap_status : end_status;
            slot_idx_in    = 3'd0;
            slot_last_in   = 1'b1;
         end
      end else if (drain_issue) begin
         slot_valid_in  = 1'b1;
         slot_word_in   = 1'b1;
         slot_status_in = ST_OK;
         slot_idx_in    = rd_ptr_ff;
         slot_last_in   = (rd_ptr_ff == drain_last_ff);
         rd_ptr_in      = rd_ptr_ff + 3'd1;
         if (rd_ptr_ff == drain_last_ff) begin
            drain_in = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (slot_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_id_ff   <= SLAVE_ID_RESET;
         reg_count_ff  <= REG_COUNT_RESET;
         bytes_ff      <= 5'd0;
         crc_ff        <= CRC_INIT;
         addr_ff       <= 8'd0;
         func_ff       <= 8'd0;
         count_ff      <= 8'd0;
         crc_lo_ff     <= 8'd0;
         done_ff       <= 1'b0;
         drain_ff      <= 1'b0;
         slot_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         slave_id_ff   <= slave_id_in;
         reg_count_ff  <= reg_count_in;
         bytes_ff      <= bytes_in;
         crc_ff        <= crc_in;
         addr_ff       <= addr_in;
         func_ff       <= func_in;
         count_ff      <= count_in;
         crc_lo_ff     <= crc_lo_in;
         done_ff       <= done_in;
         drain_ff      <= drain_in;
         slot_valid_ff <= slot_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff      <= rd_ptr_in;
      drain_last_ff  <= drain_last_in;
      slot_word_ff   <= slot_word_in;
      slot_status_ff <= slot_status_in;
      slot_idx_ff    <= slot_idx_in;
      slot_last_ff   <= slot_last_in;
      if (slot_adv) begin
         rsp_status_ff <= slot_status_ff;
         rsp_idx_ff    <= slot_idx_ff;
         rsp_value_ff  <= slot_word_ff ? mem_rd_data : 16'd0;
         rsp_last_ff   <= slot_last_ff;
      end
   end

   mrrc_word_store #(
      .DEPTH  (WORDS),
      .ADDR_W (IDX_W)
   ) u_word_store (
      .clock   (clock),
      .wr_hi   (acc && word_wr && !body_off[0]),
      .wr_lo   (acc && word_wr && body_off[0]),
      .wr_addr (body_off[IDX_W:1]),
      .wr_data (req_data_byte),
      .rd_en   (drain_issue),
      .rd_addr (rd_ptr_ff[IDX_W-1:0]),
      .rd_data (mem_rd_data)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_reg_index = rsp_idx_ff;
   assign rsp_reg_value = rsp_value_ff;
   assign rsp_last      = rsp_last_ff;

`ifndef SYNTHESIS
   a_err_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_last)
      else $error("error result without last flag");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_reg_index == 3'd0 && rsp_reg_value == 16'd0)
      else $error("error result carries index or value");

   a_no_write_in_drain: assert property (@(posedge clock) disable iff (reset)
      acc && word_wr |-> !drain_ff)
      else $error("word store written while draining");

   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      drain_ff |-> rd_ptr_ff <= drain_last_ff)
      else $error("drain pointer past last word");

   a_slot_exclusive: assert property (@(posedge clock) disable iff (reset)
      acc && needs_slot |-> !drain_ff)
      else $error("status result taken while draining");
`endif

endmodule

@@ bench/tb_modbus_rtu_read_reply_checker.sv @@
// tb_modbus_rtu_read_reply_checker: feeds modbus rtu read replies, gaps and noise into the
// reply checker, predicts every status and register word and compares each result transfer
// depends on mrrc_pkg and modbus_rtu_read_reply_checker
module tb_modbus_rtu_read_reply_checker;
   timeunit 1ns;
   timeprecision 1ps;
   import mrrc_pkg::*;

   localparam int MAX_REGS = 8;

   typedef struct {
      logic       op;
      logic [7:0] data;
   } rx_item_type;

   typedef struct {
      status_type  status;
      logic [2:0]  index;
      logic [15:0] value;
      logic        last;
   } reply_result_type;

   typedef enum {
      FK_GOOD, FK_BAD_ID, FK_BAD_FUNC, FK_BAD_COUNT, FK_BAD_CRC, FK_EXCEPTION,
      FK_TRUNCATED, FK_OVERRUN, FK_NOISE, FK_SILENT, FK_OPEN
   } frame_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_op = OP_BYTE;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   status_type  rsp_status;
   logic [2:0]  rsp_reg_index;
   logic [15:0] rsp_reg_value;
   logic        rsp_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = 3'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   rx_item_type      reply_bytes[$];
   rx_item_type      next_item;
   reply_result_type expected_replies[$];
   reply_result_type want;
   int               errors = 0;
   int               send_idle_pct = 0;
   int               recv_stall_pct = 0;

   logic [7:0]  cfg_slave_id = SLAVE_ID_RESET;
   logic [3:0]  cfg_reg_count = REG_COUNT_RESET;

   logic [4:0]  seen_cnt = 5'd0;
   logic [15:0] crc_acc = CRC_INIT;
   logic [7:0]  addr_b = 8'd0;
   logic [7:0]  func_b = 8'd0;
   logic [7:0]  count_b = 8'd0;
   logic [7:0]  crc_lo_b = 8'd0;
   logic [15:0] words [MAX_REGS];
   logic        frame_done = 1'b0;

   modbus_rtu_read_reply_checker #(.MAX_REGS(MAX_REGS)) u_dut (.*);

   always #1 clock = ~clock;

   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc;
      for (int k = 0; k < 8; k++) begin
         if (c[0] ^ b[k]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   function automatic int frame_regs();
      if (cfg_reg_count == 4'd0) begin
         return 1;
      end
      if (cfg_reg_count > MAX_REGS) begin
         return MAX_REGS;
      end
      return int'(cfg_reg_count);
   endfunction

   function void predict_reply(input logic op, input logic [7:0] b);
      int          n;
      int          pos;
      logic [15:0] got;
      status_type  st;
      if (op == OP_GAP) begin
         if (!frame_done) begin
            if (seen_cnt == 5'd0) begin
               st = ST_NO_REPLY;
            end else if (seen_cnt == 5'd5 && (func_b & FUNC_EXC_BIT) != 8'd0) begin
               st = ST_EXCEPTION;
            end else begin
               st = ST_SHORT;
            end
            expected_replies.push_back('{st, 3'd0, 16'd0, 1'b1});
         end
         seen_cnt   = 5'd0;
         crc_acc    = CRC_INIT;
         addr_b     = 8'd0;
         func_b     = 8'd0;
         count_b    = 8'd0;
         crc_lo_b   = 8'd0;
         frame_done = 1'b0;
         return;
      end
      if (frame_done) begin
         return;
      end
      n   = frame_regs();
      pos = int'(seen_cnt);
      if (pos + 2 < 5 + 2 * n) begin
         crc_acc = crc_step(crc_acc, b);
         case (pos)
            0: begin
               addr_b = b;
            end
            1: begin
               func_b = b;
            end
            2: begin
               count_b = b;
            end
            default: begin
               if ((pos - 3) % 2 == 0) begin
                  words[(pos - 3) / 2][15:8] = b;
               end else begin
                  words[(pos - 3) / 2][7:0] = b;
               end
            end
         endcase
         seen_cnt = seen_cnt + 5'd1;
      end else if (pos + 2 == 5 + 2 * n) begin
         crc_lo_b = b;
         seen_cnt = seen_cnt + 5'd1;
      end else begin
         frame_done = 1'b1;
         got = {b, crc_lo_b};
         if (addr_b != cfg_slave_id) begin
            st = ST_BAD_ID;
         end else if (func_b != FUNC_READ_HOLD) begin
            st = ST_BAD_FUNC;
         end else if (int'(count_b) != 2 * n) begin
            st = ST_BAD_COUNT;
         end else if (got != crc_acc) begin
            st = ST_CRC;
         end else begin
            st = ST_OK;
         end
         if (st != ST_OK) begin
            expected_replies.push_back('{st, 3'd0, 16'd0, 1'b1});
         end else begin
            for (int k = 0; k < n; k++) begin
               expected_replies.push_back('{ST_OK, 3'(k), words[k], (k == n - 1)});
            end
         end
      end
   endfunction

   // request side: one transfer per handshake, payload held while waiting
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_reply(req_op, req_data_byte);
         end
         if (!req_valid || req_ready) begin
            if (reply_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_item = reply_bytes.pop_front();
               req_valid     <= 1'b1;
               req_op        <= next_item.op;
               req_data_byte <= next_item.data;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_replies.size() == 0) begin
               $display("%0t unexpected transfer: expected none, actual %0d %0d %h %b", $time,
                        rsp_status, rsp_reg_index, rsp_reg_value, rsp_last);
               errors++;
            end else begin
               want = expected_replies.pop_front();
               if (rsp_status !== want.status || rsp_reg_index !== want.index ||
                   rsp_reg_value !== want.value || rsp_last !== want.last) begin
                  $display("%0t mismatch: expected %0d %0d %h %b, actual %0d %0d %h %b", $time,
                           want.status, want.index, want.value, want.last,
                           rsp_status, rsp_reg_index, rsp_reg_value, rsp_last);
                  errors++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic csr_write(input logic reg_sel, input logic [31:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_sel, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (reg_sel == REG_SLAVE_ID) begin
         cfg_slave_id = value[7:0];
      end else begin
         cfg_reg_count = value[3:0];
      end
   endtask

   task automatic set_phase(input logic [7:0] slave, input logic [3:0] count,
                            input int send_pct, input int stall_pct);
      csr_write(REG_SLAVE_ID, 32'(slave));
      csr_write(REG_REG_COUNT, 32'(count));
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
   endtask

   task automatic push_reply(input frame_kind_type kind, input int fixed_word = -1);
      logic [7:0]  frame [24];
      logic [15:0] crc;
      logic [15:0] w;
      int          n;
      int          len;
      int          body;
      int          cut;
      int          r;
      n    = frame_regs();
      len  = 5 + 2 * n;
      body = len - 2;
      frame[0] = cfg_slave_id;
      frame[1] = FUNC_READ_HOLD;
      frame[2] = 8'(2 * n);
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(7);
         if (fixed_word >= 0) begin
            w = 16'(fixed_word);
         end else if (r == 0) begin
            w = 16'h0000;
         end else if (r == 1) begin
            w = 16'hFFFF;
         end else begin
            w = 16'($urandom);
         end
         frame[3 + 2 * k] = w[15:8];
         frame[4 + 2 * k] = w[7:0];
      end
      case (kind)
         FK_BAD_ID: begin
            frame[0] ^= 8'($urandom_range(1, 255));
         end
         FK_BAD_FUNC: begin
            frame[1] ^= 8'($urandom_range(1, 255));
         end
         FK_BAD_COUNT: begin
            frame[2] ^= 8'($urandom_range(1, 255));
         end
         FK_EXCEPTION: begin
            frame[1] = FUNC_READ_HOLD | FUNC_EXC_BIT;
            frame[2] = 8'($urandom);
            body = 3;
         end
         default: begin
         end
      endcase
      crc = CRC_INIT;
      for (int k = 0; k < body; k++) begin
         crc = crc_step(crc, frame[k]);
      end
      frame[body]     = crc[7:0];
      frame[body + 1] = crc[15:8];
      if (kind == FK_BAD_CRC) begin
         frame[body + $urandom_range(1)] ^= 8'($urandom_range(1, 255));
      end
      case (kind)
         FK_TRUNCATED: begin
            cut = $urandom_range(1, len - 1);
         end
         FK_OPEN: begin
            cut = $urandom_range(6, len - 1);
         end
         FK_NOISE: begin
            cut = $urandom_range(1, len + 2);
            for (int k = 0; k < cut; k++) begin
               frame[k] = 8'($urandom);
            end
         end
         FK_SILENT: begin
            cut = 0;
         end
         default: begin
            cut = body + 2;
         end
      endcase
      for (int k = 0; k < cut; k++) begin
         reply_bytes.push_back('{OP_BYTE, frame[k]});
      end
      if (kind == FK_OVERRUN) begin
         repeat ($urandom_range(1, 3)) reply_bytes.push_back('{OP_BYTE, 8'($urandom)});
      end
      if (kind != FK_OPEN) begin
         reply_bytes.push_back('{OP_GAP, 8'($urandom)});
      end
   endtask

   task automatic push_random(input int frames);
      int             r;
      frame_kind_type kind;
      repeat (frames) begin
         r = $urandom_range(99);
         if (r < 55) begin
            kind = FK_GOOD;
         end else if (r < 60) begin
            kind = FK_BAD_ID;
         end else if (r < 65) begin
            kind = FK_BAD_FUNC;
         end else if (r < 70) begin
            kind = FK_BAD_COUNT;
         end else if (r < 77) begin
            kind = FK_BAD_CRC;
         end else if (r < 82) begin
            kind = FK_EXCEPTION;
         end else if (r < 88) begin
            kind = FK_TRUNCATED;
         end else if (r < 92) begin
            kind = FK_OVERRUN;
         end else if (r < 96) begin
            kind = FK_NOISE;
         end else begin
            kind = FK_SILENT;
         end
         push_reply(kind);
      end
   endtask

   // wait until every transfer is done, then let the block settle
   task automatic settle();
      do begin
         @(negedge clock);
      end while (reply_bytes.size() != 0 || req_valid || expected_replies.size() != 0);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      set_phase(SLAVE_ID_RESET, 4'd1, 0, 0);
      push_reply(FK_OVERRUN, 16'hFFFF);
      push_reply(FK_GOOD, 16'h0000);
      push_reply(FK_SILENT);
      push_reply(FK_EXCEPTION);
      push_reply(FK_TRUNCATED);
      settle();

      // leaves a long frame open so that the count drops under it
      set_phase(8'h00, 4'd8, 0, 0);
      push_reply(FK_GOOD);
      push_random(2);
      push_reply(FK_OPEN);
      settle();

      set_phase(8'hFF, 4'd0, 82, 0);
      push_reply(FK_NOISE);
      push_random(5);
      settle();

      set_phase(8'h5A, 4'd15, 0, 82);
      push_random(2);
      settle();

      set_phase(8'hA5, 4'd3, 29, 29);
      push_random(3);
      settle();

      set_phase(8'($urandom), 4'($urandom_range(1, 8)), 0, 0);
      push_random(2);
      settle();

      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/mrrc_pkg.sv
rtl/mrrc_word_store.sv
rtl/modbus_rtu_read_reply_checker.sv
bench/tb_modbus_rtu_read_reply_checker.sv
